### hdl/fps_pkg.sv
package fps_pkg;

    localparam int KNOB_COUNT = 8;
    localparam int IDX_W      = $clog2(KNOB_COUNT);
    localparam int SAMPLE_W   = 10;
    localparam int VALUE_W    = 11;
    localparam int ID_W       = 4;
    localparam int COUNT_W    = 8;

    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    // configuration register map
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LONG_PRESS  = 2'd0,
        CFG_SHORT_PRESS = 2'd1,
        CFG_DEAD_ZONE   = 2'd2
    } cfg_index_t;

    localparam logic [COUNT_W-1:0]  LONG_PRESS_RESET  = 8'd100;
    localparam logic [COUNT_W-1:0]  SHORT_PRESS_RESET = 8'd5;
    localparam logic [SAMPLE_W-1:0] DEAD_ZONE_RESET   = 10'd16;

    // scanner result for one poll
    typedef struct packed {
        logic                       valid;
        logic [ID_W-1:0]            id;
        logic signed [VALUE_W-1:0]  value;
        logic [IDX_W-1:0]           position;
    } scan_res_t;

    // button verdict for one poll
    typedef struct packed {
        logic short_press;
        logic long_press;
    } button_res_t;

endpackage

### hdl/fps_scan_unit.sv
module fps_scan_unit
    import fps_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  logic                adc_ready,
    input  logic [SAMPLE_W-1:0] knob_sample,
    input  logic                glide_level,
    input  logic [SAMPLE_W-1:0] dead_zone,
    output scan_res_t           res
);

    typedef enum logic [2:0] {
        SCAN_IDLE  = 3'b001,
        SCAN_SET   = 3'b010,
        SCAN_GLIDE = 3'b100
    } scan_state_t;

    localparam logic [IDX_W-1:0] KNOB_LFO_WAVE  = 3'd1;
    localparam logic [IDX_W-1:0] KNOB_VCO1_TUNE = 3'd4;
    localparam logic [IDX_W-1:0] KNOB_VCO2_TUNE = 3'd5;
    localparam logic [IDX_W-1:0] KNOB_VCO1_OCT  = 3'd6;
    localparam logic [IDX_W-1:0] KNOB_VCO2_OCT  = 3'd7;
    localparam logic [IDX_W-1:0] KNOB_LAST      = IDX_W'(KNOB_COUNT - 1);
    localparam logic [ID_W-1:0]  GLIDE_ID       = 4'd8;

    scan_state_t               scan_phase_reg, scan_phase_next;
    logic [IDX_W-1:0]          scan_index_reg, scan_index_next;
    logic signed [VALUE_W-1:0] knob_value;
    logic signed [VALUE_W-1:0] tune;
    logic [VALUE_W-1:0]        tune_mag;
    logic [2:0]                band4;
    logic [2:0]                band5;

    // four bands split at 256/512/768, five at 204/408/612/816
    always_comb begin
        if (knob_sample < 10'd256)      band4 = 3'd0;
        else if (knob_sample < 10'd512) band4 = 3'd1;
        else if (knob_sample < 10'd768) band4 = 3'd2;
        else                            band4 = 3'd3;

        if (knob_sample < 10'd204)      band5 = 3'd0;
        else if (knob_sample < 10'd408) band5 = 3'd1;
        else if (knob_sample < 10'd612) band5 = 3'd2;
        else if (knob_sample < 10'd816) band5 = 3'd3;
        else                            band5 = 3'd4;
    end

    // tune offset around mid scale, zeroed while inside the dead zone
    assign tune     = $signed({1'b0, knob_sample}) - 11'sd512;
    assign tune_mag = tune[VALUE_W-1] ? VALUE_W'(-tune) : VALUE_W'(tune);

    always_comb begin
        case (scan_index_reg)
            KNOB_LFO_WAVE:                  knob_value = $signed({8'd0, band4});
            KNOB_VCO1_TUNE, KNOB_VCO2_TUNE: knob_value = (tune_mag < {1'b0, dead_zone})
                                                         ? '0 : tune;
            KNOB_VCO1_OCT, KNOB_VCO2_OCT:   knob_value = $signed({8'd0, band5});
            default:                        knob_value = $signed({1'b0, knob_sample});
        endcase
    end

    always_comb begin
        scan_phase_next = scan_phase_reg;
        scan_index_next = scan_index_reg;
        res.valid       = 1'b0;
        res.id          = '0;
        res.value       = '0;
        unique case (scan_phase_reg)
            SCAN_IDLE: begin
                if (adc_ready) begin
                    scan_index_next = '0;
                    scan_phase_next = SCAN_SET;
                end
            end
            SCAN_SET: begin
                res.valid       = 1'b1;
                res.id          = {1'b0, scan_index_reg};
                res.value       = knob_value;
                scan_index_next = scan_index_reg + 1'b1;
                if (scan_index_reg == KNOB_LAST) begin
                    scan_phase_next = SCAN_GLIDE;
                end
            end
            SCAN_GLIDE: begin
                res.valid       = 1'b1;
                res.id          = GLIDE_ID;
                res.value       = $signed({10'd0, glide_level});
                scan_phase_next = SCAN_IDLE;
            end
            default: begin
                scan_phase_next = SCAN_IDLE;
            end
        endcase
        res.position = scan_index_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_phase_reg <= SCAN_IDLE;
            scan_index_reg <= '0;
        end else if (step) begin
            scan_phase_reg <= scan_phase_next;
            scan_index_reg <= scan_index_next;
        end
    end

endmodule

### hdl/fps_button_unit.sv
module fps_button_unit
    import fps_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step,
    input  logic               button_level,
    input  logic               tick,
    input  logic [COUNT_W-1:0] long_count,
    input  logic [COUNT_W-1:0] short_count,
    output button_res_t        res
);

    typedef enum logic [2:0] {
        BTN_IDLE = 3'b001,
        BTN_WAIT = 3'b010,
        BTN_END  = 3'b100
    } btn_state_t;

    btn_state_t         btn_phase_reg, btn_phase_next;
    logic [COUNT_W-1:0] press_ticks_reg, press_ticks_next;
    logic               clear;

    always_comb begin
        btn_phase_next  = btn_phase_reg;
        clear           = 1'b0;
        res.short_press = 1'b0;
        res.long_press  = 1'b0;
        unique case (btn_phase_reg)
            BTN_IDLE: begin
                if (button_level) begin
                    btn_phase_next = BTN_WAIT;
                    clear          = 1'b1;
                end
            end
            BTN_WAIT: begin
                if (!button_level) btn_phase_next = BTN_END;
            end
            BTN_END: begin
                // verdict uses the count before this poll's tick
                if (press_ticks_reg > long_count)       res.long_press  = 1'b1;
                else if (press_ticks_reg > short_count) res.short_press = 1'b1;
                btn_phase_next = BTN_IDLE;
            end
            default: begin
                btn_phase_next = BTN_IDLE;
            end
        endcase

        // clear beats tick; count saturates
        if (clear)                          press_ticks_next = '0;
        else if (tick && !(&press_ticks_reg)) press_ticks_next = press_ticks_reg + 1'b1;
        else                                press_ticks_next = press_ticks_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            btn_phase_reg   <= BTN_IDLE;
            press_ticks_reg <= '0;
        end else if (step) begin
            btn_phase_reg   <= btn_phase_next;
            press_ticks_reg <= press_ticks_next;
        end
    end

endmodule

### hdl/front_panel_scanner.sv
// Channel   Dir  Handshake                 Payload
// -------   ---  ------------------------  ---------------------------------------------
// s_        in   s_tvalid / s_tready       one panel poll request (s_tdata)
// m_        out  m_tvalid / m_tready       one result per poll (m_tdata)
// cfg_      in   cfg_valid / cfg_ready     register write: cfg_index, cfg_data
//
// One poll request per cycle sustained while m_tready is high; requests pass through
// the input register, then the result register. Stall: m_tready low holds the result
// register; s_tready drops once the input register also holds a request.
// Reset (aresetn low, synchronous): scan idle at knob 0, button idle, press
// count zero, registers at 100 / 5 / 16. cfg_ready is always high.
module front_panel_scanner
    import fps_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [0] adc_ready, [10:1] knob_sample, [11] glide_level, [12] button_level,
    // [13] tick, [15:14] zero
    input  logic [S_TDATA_W-1:0]  s_tdata,

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [0] param_valid, [4:1] param_id, [15:5] param_value (signed),
    // [18:16] scan_position, [19] short_press, [20] long_press, [23:21] zero
    output logic [M_TDATA_W-1:0]  m_tdata,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // configuration registers
    logic [COUNT_W-1:0]  long_count_reg;
    logic [COUNT_W-1:0]  short_count_reg;
    logic [SAMPLE_W-1:0] dead_zone_reg;

    // input register
    logic                 in_valid_reg;
    logic [S_TDATA_W-1:0] in_data_reg;

    // result register
    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;

    logic        out_free;
    logic        step;
    scan_res_t   scan_res;
    button_res_t btn_res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            long_count_reg  <= LONG_PRESS_RESET;
            short_count_reg <= SHORT_PRESS_RESET;
            dead_zone_reg   <= DEAD_ZONE_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_LONG_PRESS:  long_count_reg  <= cfg_data[COUNT_W-1:0];
                CFG_SHORT_PRESS: short_count_reg <= cfg_data[COUNT_W-1:0];
                CFG_DEAD_ZONE:   dead_zone_reg   <= cfg_data;
                default:         ;  // unmapped index, write dropped
            endcase
        end
    end

    // the held request moves on whenever the result register can take it
    assign out_free = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg <= s_tdata;
        end
    end

    fps_scan_unit u_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .adc_ready   (in_data_reg[0]),
        .knob_sample (in_data_reg[10:1]),
        .glide_level (in_data_reg[11]),
        .dead_zone   (dead_zone_reg),
        .res         (scan_res)
    );

    fps_button_unit u_button (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (step),
        .button_level (in_data_reg[12]),
        .tick         (in_data_reg[13]),
        .long_count   (long_count_reg),
        .short_count  (short_count_reg),
        .res          (btn_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_data_reg <= {3'b000,
                             btn_res.long_press,
                             btn_res.short_press,
                             scan_res.position,
                             scan_res.value,
                             scan_res.id,
                             scan_res.valid};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
